/* design/nvbp_pkg.sv */
// shared types, constants and helpers for the nix vector bit packer
// no dependencies

package nvbp_pkg;

  localparam int WORD_BITS  = 32;
  localparam int OFF_W      = 5;
  localparam int FIELD_BITS = 16;
  localparam int FW_W       = 5;
  localparam int REM_W      = 9;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_REWIND  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                 en;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] data;
  } bank_wr_t;

  // smallest w in 1..16 with 2**w >= count
  function automatic logic [FW_W-1:0] field_width(input logic [FIELD_BITS-1:0] count);
    logic [FIELD_BITS-1:0] c1;
    logic [FW_W-1:0]       w;
    c1 = count - FIELD_BITS'(1);
    w  = FW_W'(1);
    if (count > FIELD_BITS'(2)) begin
      for (int i = 0; i < FIELD_BITS; i++) begin
        if (c1[i]) begin
          w = FW_W'(i + 1);
        end
      end
    end
    return w;
  endfunction

endpackage

/* design/nvbp_bank.sv */
// one bank of vector words: bit-masked write and registered read at one address
// depends on nvbp_pkg

module nvbp_bank
  import nvbp_pkg::*;
#(
  parameter int ADDR_W = 2
) (
  input  logic                 clk,
  input  logic [ADDR_W-1:0]    addr,
  input  bank_wr_t             wr,
  input  logic                 rd_en,
  output logic [WORD_BITS-1:0] rd_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (wr.mask[i]) begin
          mem[addr][i] <= wr.data[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

/* design/nix_vector_bit_packer_core.sv */
// nix vector bit packer top level: command decode, size tracking, field placement
// depends on nvbp_pkg and nvbp_bank
//
// Usage: one input transaction carries a command (clear, append, extract, rewind),
// a value to append and a neighbor count that sets the field width (1 to 16 bits).
// Every input transaction yields exactly one result transaction with the extracted
// field, an error flag and the bits remaining between used and size.
// The vector is kept MSB first in 32-bit words split over an even and an odd bank,
// so a field that spans two words touches each bank once.
// Pipeline: a transaction passes through the input stage, the bank read stage and
// the result register, in that order.
// Throughput: one transaction per cycle when not stalled; each command is placed in
// one pass over the input stage and the bank read of an extract lands in the next stage.
// Reset (rst_n low, synchronous) empties the pipeline, sets used to 0 and size to
// 32 and marks every word as zero; the banks themselves are not swept.
// When the receiver holds out_stall, the result register holds its contents and
// the two inner stages keep filling; in_stall rises only when all three are full.

module nix_vector_bit_packer_core
  import nvbp_pkg::*;
#(
  parameter int STORE_WORDS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [FIELD_BITS-1:0] in_field_value,
  input  logic [FIELD_BITS-1:0] in_neighbor_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_BITS-1:0] out_read_value,
  output logic                  out_error,
  output logic [REM_W-1:0]      out_bits_remaining
);

  localparam int CAP     = STORE_WORDS * WORD_BITS;
  localparam int POS_W   = $clog2(CAP + 1);
  localparam int SUM_W   = POS_W + 1;
  localparam int BANK_AW = ($clog2(STORE_WORDS) > 1) ? $clog2(STORE_WORDS) - 1 : 1;
  localparam int WX_W    = BANK_AW + 2;

  // pipeline control
  logic out_en, b_en, a_fire;

  // input stage
  logic                  a_valid_r;
  cmd_t                  a_cmd_r;
  logic [FIELD_BITS-1:0] a_val_r;
  logic [FIELD_BITS-1:0] a_count_r;

  // vector state
  logic [POS_W-1:0]       bits_used_r, used_nxt;
  logic [POS_W-1:0]       bits_size_r, size_nxt;
  logic [STORE_WORDS-1:0] valid_r, valid_nxt;

  // input stage decode
  logic [FW_W-1:0]       w;
  logic [SUM_W-1:0]      sum;
  logic [OFF_W-1:0]      off;
  logic [WX_W-1:0]       f, g, last, wo;
  logic                  spans, lo_fresh, hi_fresh, lo_vld, hi_vld;
  logic                  app_ok, ext_ok, a_err;
  logic [POS_W-1:0]      size_grow;
  logic [FIELD_BITS-1:0] fld16, mask16;
  logic [2*WORD_BITS-1:0] win_d, win_m;
  logic [WORD_BITS-1:0]  lo_mask, hi_mask;
  logic                  lo_we, hi_we;
  logic [STORE_WORDS-1:0] valid_set;
  logic [REM_W-1:0]      rem;
  bank_wr_t              even_wr, odd_wr;
  logic [BANK_AW-1:0]    even_addr, odd_addr;
  logic [WORD_BITS-1:0]  even_q, odd_q;

  // read stage
  logic                  b_valid_r, b_ok_r, b_err_r, b_f0_r, b_lo_vld_r, b_hi_vld_r;
  logic [REM_W-1:0]      b_rem_r;
  logic [OFF_W-1:0]      b_off_r;
  logic [FW_W-1:0]       b_w_r;
  logic [WORD_BITS-1:0]  b_lo, b_hi;
  logic [2*WORD_BITS-1:0] b_win;
  logic [FIELD_BITS-1:0] b_top, b_rd;

  // result register
  logic                  out_valid_r;
  logic [FIELD_BITS-1:0] out_read_value_r;
  logic                  out_error_r;
  logic [REM_W-1:0]      out_bits_remaining_r;

  assign out_en   = !out_valid_r || !out_stall;
  assign b_en     = !b_valid_r || out_en;
  assign in_stall = a_valid_r && !b_en;
  assign a_fire   = a_valid_r && b_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_cmd_r   <= cmd_t'(in_cmd);
      a_val_r   <= in_field_value;
      a_count_r <= in_neighbor_count;
    end
  end

  // field geometry against the current state
  always_comb begin
    w      = field_width(a_count_r);
    sum    = SUM_W'(bits_used_r) + SUM_W'(w);
    off    = bits_used_r[OFF_W-1:0];
    f      = WX_W'(bits_used_r >> OFF_W);
    g      = f + WX_W'(1);
    last   = WX_W'((sum - SUM_W'(1)) >> OFF_W);
    wo     = WX_W'((SUM_W'(bits_size_r) + SUM_W'(WORD_BITS - 1)) >> OFF_W);
    spans  = (6'(off) + 6'(w)) > 6'(WORD_BITS);
    lo_vld = |(valid_r & (STORE_WORDS'(1) << f));
    hi_vld = |(valid_r & (STORE_WORDS'(1) << g));
    // words newly covered by size growth, or cleared, start from zero
    lo_fresh  = (f >= wo) || !lo_vld;
    hi_fresh  = (g >= wo) || !hi_vld;
    size_grow = POS_W'(SUM_W'(bits_size_r)
                + (SUM_W'(last - wo + WX_W'(1)) << OFF_W));
    valid_set = (STORE_WORDS'(1) << f) | (spans ? (STORE_WORDS'(1) << g) : '0);
    mask16 = ~(16'hFFFF >> w);
    fld16  = 16'(a_val_r << (FW_W'(FIELD_BITS) - w)) & mask16;
    win_d  = {fld16, {(2*WORD_BITS-FIELD_BITS){1'b0}}} >> off;
    win_m  = {mask16, {(2*WORD_BITS-FIELD_BITS){1'b0}}} >> off;
  end

  always_comb begin
    used_nxt  = bits_used_r;
    size_nxt  = bits_size_r;
    valid_nxt = valid_r;
    app_ok    = 1'b0;
    ext_ok    = 1'b0;
    a_err     = 1'b0;
    case (a_cmd_r)
      CMD_CLEAR: begin
        used_nxt  = '0;
        size_nxt  = POS_W'(WORD_BITS);
        valid_nxt = '0;
      end
      CMD_APPEND: begin
        if (sum > SUM_W'(CAP)) begin
          a_err = 1'b1;
        end else begin
          app_ok    = 1'b1;
          used_nxt  = POS_W'(sum);
          valid_nxt = valid_r | valid_set;
          if (last >= wo) begin
            size_nxt = size_grow;
          end
        end
      end
      CMD_EXTRACT: begin
        if (sum > SUM_W'(bits_size_r)) begin
          a_err = 1'b1;
        end else begin
          ext_ok   = 1'b1;
          used_nxt = POS_W'(sum);
        end
      end
      CMD_REWIND: begin
        size_nxt = bits_used_r;
        used_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    lo_we     = a_fire && app_ok;
    hi_we     = a_fire && app_ok && spans && (g < WX_W'(STORE_WORDS));
    lo_mask   = lo_fresh ? '1 : win_m[2*WORD_BITS-1:WORD_BITS];
    hi_mask   = hi_fresh ? '1 : win_m[WORD_BITS-1:0];
    rem       = (size_nxt > used_nxt) ? REM_W'(size_nxt - used_nxt) : '0;
  end

  // word f sits in the even bank when f is even, word f+1 in the other one
  always_comb begin
    odd_addr  = f[BANK_AW:1];
    even_addr = f[0] ? g[BANK_AW:1] : f[BANK_AW:1];
    even_wr.en   = f[0] ? hi_we : lo_we;
    even_wr.mask = f[0] ? hi_mask : lo_mask;
    even_wr.data = f[0] ? win_d[WORD_BITS-1:0] : win_d[2*WORD_BITS-1:WORD_BITS];
    odd_wr.en    = f[0] ? lo_we : hi_we;
    odd_wr.mask  = f[0] ? lo_mask : hi_mask;
    odd_wr.data  = f[0] ? win_d[2*WORD_BITS-1:WORD_BITS] : win_d[WORD_BITS-1:0];
  end

  nvbp_bank #(.ADDR_W(BANK_AW)) u_even_bank (
    .clk     (clk),
    .addr    (even_addr),
    .wr      (even_wr),
    .rd_en   (b_en),
    .rd_data (even_q)
  );

  nvbp_bank #(.ADDR_W(BANK_AW)) u_odd_bank (
    .clk     (clk),
    .addr    (odd_addr),
    .wr      (odd_wr),
    .rd_en   (b_en),
    .rd_data (odd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_used_r <= '0;
      bits_size_r <= POS_W'(WORD_BITS);
      valid_r     <= '0;
    end else if (a_fire) begin
      bits_used_r <= used_nxt;
      bits_size_r <= size_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_ok_r     <= ext_ok;
      b_err_r    <= a_err;
      b_rem_r    <= rem;
      b_off_r    <= off;
      b_w_r      <= w;
      b_f0_r     <= f[0];
      b_lo_vld_r <= lo_vld;
      b_hi_vld_r <= hi_vld;
    end
  end

  // pull the field out of the two-word window
  always_comb begin
    b_lo  = (b_f0_r ? odd_q : even_q) & {WORD_BITS{b_lo_vld_r}};
    b_hi  = (b_f0_r ? even_q : odd_q) & {WORD_BITS{b_hi_vld_r}};
    b_win = {b_lo, b_hi} << b_off_r;
    b_top = b_win[2*WORD_BITS-1:2*WORD_BITS-FIELD_BITS];
    b_rd  = b_ok_r ? (b_top >> (FW_W'(FIELD_BITS) - b_w_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && b_valid_r) begin
      out_read_value_r     <= b_rd;
      out_error_r          <= b_err_r;
      out_bits_remaining_r <= b_rem_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_read_value_r;
  assign out_error          = out_error_r;
  assign out_bits_remaining = out_bits_remaining_r;

`ifndef ASSERT_OFF
  a_size_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    bits_size_r <= POS_W'(CAP))
    else $error("vector size beyond store capacity");

  a_used_covered: assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(bits_used_r) <= ((SUM_W'(bits_size_r) + SUM_W'(WORD_BITS - 1))
                            & ~SUM_W'(WORD_BITS - 1)))
    else $error("used bits run past the covered words");

  a_clear_wipes: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && a_cmd_r == CMD_CLEAR) |=> (valid_r == '0))
    else $error("clear left words marked as written");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_read_value_r == '0))
    else $error("error transaction carries a nonzero field");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> !in_stall)
    else $error("input stalled with an empty input stage");
`endif

endmodule

/* verif/tb.sv */
// self-checking testbench for nix_vector_bit_packer_core: directed and random command
// streams checked against an in-bench packer predictor, under random idling and stalls
// depends on nvbp_pkg and the packer rtl

module tb;
  import nvbp_pkg::*;

  localparam int STORE_WORDS = 8;
  localparam int STORE_BITS  = STORE_WORDS * WORD_BITS;
  localparam int QUIET_LIMIT = 5000;
  localparam int END_CYCLES  = 20;

  typedef struct packed {
    logic [FIELD_BITS-1:0] read_value;
    logic                  error;
    logic [REM_W-1:0]      bits_remaining;
  } packer_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cmd_t                  in_cmd = CMD_CLEAR;
  logic [FIELD_BITS-1:0] in_field_value = '0;
  logic [FIELD_BITS-1:0] in_neighbor_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FIELD_BITS-1:0] out_read_value;
  logic                  out_error;
  logic [REM_W-1:0]      out_bits_remaining;

  // predictor state
  logic [WORD_BITS-1:0] packer_words [STORE_WORDS];
  int                   packer_used;
  int                   packer_size;
  packer_result_t       pending_results [$];

  int n_fail = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  nix_vector_bit_packer_core #(
    .STORE_WORDS(STORE_WORDS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_field_value    (in_field_value),
    .in_neighbor_count (in_neighbor_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_error         (out_error),
    .out_bits_remaining(out_bits_remaining)
  );

  always #2 clk = ~clk;

  function automatic int width_of_count(logic [FIELD_BITS-1:0] count);
    int w;
    w = 1;
    while (w < 16 && (1 << w) < int'(count)) w++;
    return w;
  endfunction

  // neighbor count that yields the given field width
  function automatic logic [FIELD_BITS-1:0] count_for_width(int w);
    int hi;
    if (w == 1) return FIELD_BITS'($urandom_range(2));
    hi = (w == 16) ? 65535 : (1 << w);
    return FIELD_BITS'($urandom_range(hi, (1 << (w - 1)) + 1));
  endfunction

  task automatic reset_packer_state();
    foreach (packer_words[k]) packer_words[k] = '0;
    packer_used = 0;
    packer_size = WORD_BITS;
  endtask

  // updates the predicted vector and queues the expected result
  task automatic apply_packer_cmd(cmd_t c, logic [FIELD_BITS-1:0] val,
                                  logic [FIELD_BITS-1:0] cnt);
    int w;
    int last_word;
    int nw;
    int pos;
    packer_result_t r;
    w = width_of_count(cnt);
    r = '0;
    case (c)
      CMD_CLEAR: begin
        reset_packer_state();
      end
      CMD_APPEND: begin
        if (packer_used + w > STORE_BITS) begin
          r.error = 1'b1;
        end else begin
          last_word = (packer_used + w - 1) / WORD_BITS;
          // size grows a word at a time, each new word starts out zero
          while ((packer_size + WORD_BITS - 1) / WORD_BITS <= last_word) begin
            packer_size += WORD_BITS;
            nw = (packer_size + WORD_BITS - 1) / WORD_BITS - 1;
            if (nw < STORE_WORDS) packer_words[nw] = '0;
          end
          for (int i = 0; i < w; i++) begin
            pos = packer_used + i;
            packer_words[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS] = val[w - 1 - i];
          end
          packer_used += w;
        end
      end
      CMD_EXTRACT: begin
        if (packer_used + w > packer_size) begin
          r.error = 1'b1;
        end else begin
          for (int i = 0; i < w; i++) begin
            pos = packer_used + i;
            r.read_value = {r.read_value[FIELD_BITS-2:0],
                            packer_words[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS]};
          end
          packer_used += w;
        end
      end
      default: begin
        packer_size = packer_used;
        packer_used = 0;
      end
    endcase
    r.bits_remaining = REM_W'(packer_size > packer_used ? packer_size - packer_used : 0);
    pending_results.push_back(r);
  endtask

  // returns at the rising edge where the transaction was taken
  task automatic send_item(cmd_t c, logic [FIELD_BITS-1:0] val, logic [FIELD_BITS-1:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_cmd            <= c;
    in_field_value    <= val;
    in_neighbor_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_packer_cmd(c, val, cnt);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results_drained();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    packer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0h, got %0h", want.read_value, out_read_value);
          n_fail++;
        end
        if (out_error !== want.error) begin
          $error("error: expected %0b, got %0b", want.error, out_error);
          n_fail++;
        end
        if (out_bits_remaining !== want.bits_remaining) begin
          $error("bits_remaining: expected %0d, got %0d",
                 want.bits_remaining, out_bits_remaining);
          n_fail++;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_fill_and_overflow();
    send_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    send_item(CMD_APPEND, 16'hFFFF, 16'd0);
    send_item(CMD_APPEND, 16'h0000, 16'd2);
    send_item(CMD_APPEND, 16'h0002, 16'd3);
    // 16-bit fields land across word boundaries
    for (int k = 0; k < 15; k++) begin
      case (k % 3)
        0:       send_item(CMD_APPEND, 16'hFFFF, 16'hFFFF);
        1:       send_item(CMD_APPEND, 16'h0000, 16'hFFFF);
        default: send_item(CMD_APPEND, 16'hA5C3, 16'hFFFF);
      endcase
    end
    send_item(CMD_APPEND, 16'h7FFF, 16'h8000);
    send_item(CMD_APPEND, 16'hFFFF, 16'h1000);
    send_item(CMD_APPEND, 16'h0001, 16'd1);
  endtask

  task automatic test_readback_and_size_errors();
    send_item(CMD_REWIND, 16'h0000, 16'h0000);
    send_item(CMD_EXTRACT, 16'hFFFF, 16'd0);
    send_item(CMD_EXTRACT, 16'h0000, 16'd2);
    send_item(CMD_EXTRACT, 16'h0000, 16'd3);
    send_item(CMD_EXTRACT, 16'h0000, 16'h8001);
    send_item(CMD_EXTRACT, 16'h0000, 16'h8000);
    send_item(CMD_REWIND, 16'hFFFF, 16'hFFFF);
    send_item(CMD_EXTRACT, 16'h0000, 16'hFFFF);
    send_item(CMD_EXTRACT, 16'h0000, 16'hFFFF);
    send_item(CMD_EXTRACT, 16'h0000, 16'd8);
    send_item(CMD_EXTRACT, 16'h0000, 16'd1);
  endtask

  // size below a word multiple after rewind, then appends run past it
  task automatic test_rewind_short_size();
    send_item(CMD_CLEAR, 16'h0000, 16'h0000);
    send_item(CMD_APPEND, 16'h0003, 16'd4);
    send_item(CMD_REWIND, 16'h0000, 16'h0000);
    send_item(CMD_APPEND, 16'hC001, 16'hFFFF);
    send_item(CMD_APPEND, 16'h8000, 16'hFFFF);
    send_item(CMD_APPEND, 16'h0001, 16'd2);
    send_item(CMD_EXTRACT, 16'h0000, 16'd2);
    send_item(CMD_EXTRACT, 16'h0000, 16'd2);
  endtask

  // mostly append runs read back after a rewind, with random noise mixed in
  task automatic run_random_sequences(int n_items);
    int sent;
    int n_app;
    int w;
    int widths [$];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        w = $urandom_range(1, 16);
        send_item(cmd_t'($urandom_range(3)), FIELD_BITS'($urandom),
                  ($urandom_range(1) != 0) ? FIELD_BITS'($urandom) : count_for_width(w));
        sent++;
      end else begin
        if ($urandom_range(3) == 0) begin
          send_item(CMD_CLEAR, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
          sent++;
        end
        n_app = $urandom_range(1, 24);
        widths.delete();
        repeat (n_app) begin
          w = $urandom_range(1, 16);
          widths.push_back(w);
          send_item(CMD_APPEND, FIELD_BITS'($urandom), count_for_width(w));
          sent++;
        end
        send_item(CMD_REWIND, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
        sent++;
        foreach (widths[k]) begin
          w = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : widths[k];
          send_item(CMD_EXTRACT, FIELD_BITS'($urandom), count_for_width(w));
          sent++;
        end
        if ($urandom_range(2) == 0) begin
          send_item(CMD_EXTRACT, FIELD_BITS'($urandom), count_for_width($urandom_range(1, 16)));
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n_items);
    wait_results_drained();
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_random_sequences(n_items);
  endtask

  task automatic test_streaming_no_idle();
    run_phase(0, 0, 340);
  endtask

  task automatic test_sender_gaps();
    run_phase(75, 0, 340);
  endtask

  task automatic test_receiver_stalls();
    run_phase(0, 75, 340);
  endtask

  task automatic test_mixed_idling();
    run_phase(7, 7, 340);
  endtask

  // long receiver hold-off so the pipeline fills and the input stalls
  task automatic test_output_backpressure();
    wait_results_drained();
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 80;
    run_random_sequences(30);
  endtask

  // sender stops until every pending transaction has come back
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    run_random_sequences(20);
    wait_results_drained();
    run_random_sequences(20);
  endtask

  initial begin
    reset_packer_state();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_fill_and_overflow();
    test_readback_and_size_errors();
    test_rewind_short_size();
    test_streaming_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_output_backpressure();
    test_drain_pause();
    wait_results_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
